>>> design/mts_pkg.sv
// Shared types, codes and sizes for the min-tracking stack.
package mts_pkg;

  localparam int unsigned DEPTH = 1024;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  localparam int unsigned DATA_W = 32;
  localparam int unsigned ACT_W = 2;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned FILL_W = 11;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic signed [DATA_W-1:0] data_t;

  localparam logic [ACT_W-1:0] ACT_PUSH = 2'd0;
  localparam logic [ACT_W-1:0] ACT_POP = 2'd1;
  localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic v_push;
    logic v_pop;
    logic m_push;
    logic m_pop;
  } mts_shift_t;

endpackage

>>> design/mts_if.sv
// Valid/ready channel interfaces for the stack requests and results.
interface mts_in_if;
  import mts_pkg::*;

  logic valid;
  logic ready;
  logic [ACT_W-1:0] action;
  logic signed [DATA_W-1:0] value;

  modport source(output valid, output action, output value, input ready);
  modport sink(input valid, input action, input value, output ready);
endinterface

interface mts_out_if;
  import mts_pkg::*;

  logic valid;
  logic ready;
  logic [STAT_W-1:0] status;
  logic signed [DATA_W-1:0] popped_value;
  logic signed [DATA_W-1:0] current_min;
  logic is_empty;
  logic [FILL_W-1:0] fill_count;

  modport source(
    output valid, output status, output popped_value, output current_min,
    output is_empty, output fill_count, input ready
  );
  modport sink(
    input valid, input status, input popped_value, input current_min,
    input is_empty, input fill_count, output ready
  );
endinterface

>>> design/mts_cell.sv
// One stack slot holding a value entry and a minimum entry, shifting with its neighbors.
module mts_cell (
  input  logic               clk,
  input  mts_pkg::mts_shift_t shift,
  input  mts_pkg::data_t     v_above,
  input  mts_pkg::data_t     m_above,
  input  mts_pkg::data_t     v_below,
  input  mts_pkg::data_t     m_below,
  output mts_pkg::data_t     v_q,
  output mts_pkg::data_t     m_q
);
  import mts_pkg::*;

  data_t v_r, v_nxt;
  data_t m_r, m_nxt;

  always_comb begin
    v_nxt = v_r;
    if (shift.v_push) begin
      v_nxt = v_above;
    end else if (shift.v_pop) begin
      v_nxt = v_below;
    end
    m_nxt = m_r;
    if (shift.m_push) begin
      m_nxt = m_above;
    end else if (shift.m_pop) begin
      m_nxt = m_below;
    end
  end

  always_ff @(posedge clk) begin
    v_r <= v_nxt;
    m_r <= m_nxt;
  end

  assign v_q = v_r;
  assign m_q = m_r;

endmodule

>>> design/min_tracking_stack_core.sv
// Top level of the min-tracking stack: control, counters, cell chain and result register.
//
// Channel   Direction  Payload
// in_item   sink       action, value
// out_item  source     status, popped_value, current_min, is_empty, fill_count
//
// Each accepted item's result appears in the output register on the next cycle.
// The stack is a row of DEPTH cells that all shift together, so the top is always cell zero.
// A new item is taken whenever the output register is empty or is being drained.
// Reset clears the counts and the result valid flag; cell contents are left as they are.
// A stalled result holds its register and blocks further items until it is taken.
module min_tracking_stack_core (
  input logic       clk,
  input logic       rst_n,
  mts_in_if.sink    in_item,
  mts_out_if.source out_item
);
  import mts_pkg::*;

  cnt_t val_cnt_r, val_cnt_nxt;
  cnt_t min_cnt_r, min_cnt_nxt;

  logic out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  data_t popped_r, popped_nxt;
  data_t cur_min_r, cur_min_nxt;
  logic is_empty_r, is_empty_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;

  mts_shift_t shift;
  data_t cell_v [DEPTH];
  data_t cell_m [DEPTH];
  data_t push_val;
  logic accept;
  logic val_full;
  logic val_empty;
  logic min_empty;
  logic push_min;

  assign accept = in_item.valid && in_item.ready;
  assign in_item.ready = !out_valid_r || out_item.ready;
  assign push_val = in_item.value;

  assign val_full = (val_cnt_r >= cnt_t'(DEPTH));
  assign val_empty = (val_cnt_r == '0);
  assign min_empty = (min_cnt_r == '0);
  assign push_min = (min_empty || (push_val <= cell_m[0])) && (min_cnt_r < cnt_t'(DEPTH));

  always_comb begin
    shift = '0;
    val_cnt_nxt = val_cnt_r;
    min_cnt_nxt = min_cnt_r;
    status_nxt = ST_OK;
    popped_nxt = '0;
    cur_min_nxt = cell_m[0];
    if (accept) begin
      case (in_item.action)
        ACT_PUSH: begin
          if (val_full) begin
            status_nxt = ST_FULL;
          end else begin
            shift.v_push = 1'b1;
            val_cnt_nxt = val_cnt_r + cnt_t'(1);
            if (push_min) begin
              shift.m_push = 1'b1;
              min_cnt_nxt = min_cnt_r + cnt_t'(1);
              cur_min_nxt = push_val;
            end
          end
        end
        ACT_POP: begin
          if (val_empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            shift.v_pop = 1'b1;
            val_cnt_nxt = val_cnt_r - cnt_t'(1);
            popped_nxt = cell_v[0];
            if (!min_empty && (cell_m[0] == cell_v[0])) begin
              shift.m_pop = 1'b1;
              min_cnt_nxt = min_cnt_r - cnt_t'(1);
              cur_min_nxt = cell_m[1];
            end
          end
        end
        default: begin
        end
      endcase
    end
    if (val_cnt_nxt == '0 || min_cnt_nxt == '0) begin
      cur_min_nxt = '0;
    end
    is_empty_nxt = (val_cnt_nxt == '0);
    fill_nxt = FILL_W'(val_cnt_nxt);
    out_valid_nxt = accept ? 1'b1 : (out_valid_r && !out_item.ready);
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    data_t v_above, m_above, v_below, m_below;
    if (i == 0) begin : g_top
      assign v_above = push_val;
      assign m_above = push_val;
    end else begin : g_mid
      assign v_above = cell_v[i-1];
      assign m_above = cell_m[i-1];
    end
    if (i == DEPTH - 1) begin : g_bot
      assign v_below = '0;
      assign m_below = '0;
    end else begin : g_inner
      assign v_below = cell_v[i+1];
      assign m_below = cell_m[i+1];
    end
    mts_cell u_cell (
      .clk     (clk),
      .shift   (shift),
      .v_above (v_above),
      .m_above (m_above),
      .v_below (v_below),
      .m_below (m_below),
      .v_q     (cell_v[i]),
      .m_q     (cell_m[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_cnt_r <= '0;
      min_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      val_cnt_r <= val_cnt_nxt;
      min_cnt_r <= min_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      popped_r <= popped_nxt;
      cur_min_r <= cur_min_nxt;
      is_empty_r <= is_empty_nxt;
      fill_r <= fill_nxt;
    end
  end

  assign out_item.valid = out_valid_r;
  assign out_item.status = status_r;
  assign out_item.popped_value = popped_r;
  assign out_item.current_min = cur_min_r;
  assign out_item.is_empty = is_empty_r;
  assign out_item.fill_count = fill_r;

  a_min_le_val: assert property (@(posedge clk) disable iff (!rst_n)
    min_cnt_r <= val_cnt_r)
    else $error("minimum stack deeper than value stack");

  a_min_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    val_cnt_r != '0 |-> min_cnt_r != '0)
    else $error("stored values without a tracked minimum");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_item.action == ACT_PUSH && !val_full |=>
      val_cnt_r == $past(val_cnt_r) + cnt_t'(1))
    else $error("accepted push did not grow the stack");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_item.action == ACT_POP && !val_empty |=>
      val_cnt_r == $past(val_cnt_r) - cnt_t'(1))
    else $error("accepted pop did not shrink the stack");

endmodule
